[sv/uvs_pkg.sv]
// Shared constants, codes and rounding helper for the UV sphere vertex generator.
package uvs_pkg;

  // Fixed formats
  localparam int TRIG_FRAC_BITS = 14;
  localparam int TRIG_W         = 16;                  // signed Q1.14 trig values
  localparam int TEX_W          = TRIG_FRAC_BITS + 1;  // saturated texcoord width
  localparam int OUT_W          = 24;
  localparam int PHASE_BITS     = 24;
  localparam int QUARTER_BITS   = PHASE_BITS - 2;
  localparam int POLY_W         = 31;                  // unsigned Q1.30 (value < 2.0)
  localparam int SIN_SHIFT      = 30 - TRIG_FRAC_BITS;

  // Divider geometry: dividend is at most index << 24 plus rounding, divisor <= 1024
  localparam int NUM_W = 35;
  localparam int DEN_W = 11;
  localparam int IDX_W = 11;

  // Default grid limits
  localparam int MAX_SEGMENTS_DEF = 1024;
  localparam int MAX_RINGS_DEF    = 1024;

  // Polynomial coefficients, unsigned Q1.30
  localparam logic [POLY_W-1:0] POLY_A = 31'd1685472546;
  localparam logic [POLY_W-1:0] POLY_B = 31'd686590532;
  localparam logic [POLY_W-1:0] POLY_C = 31'd74859810;

  // Register indexes
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_SLICES = 2'd1;
  localparam logic [1:0] REG_LOOPS  = 2'd2;

  // Attribute kinds
  localparam logic [2:0] KIND_POS = 3'd0;
  localparam logic [2:0] KIND_NRM = 3'd1;
  localparam logic [2:0] KIND_TEX = 3'd2;
  localparam logic [2:0] KIND_TAN = 3'd3;
  localparam logic [2:0] KIND_BIN = 3'd4;

  // Shift right by the trig fraction width, rounding half away from zero
  function automatic logic signed [47:0] round_q(input logic signed [47:0] v);
    logic [47:0] m;
    m = v[47] ? 48'(-v) : 48'(v);
    m = (m + (48'(1) << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
    return v[47] ? -$signed(m) : $signed(m);
  endfunction

endpackage

[sv/uvs_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module uvs_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [uvs_pkg::NUM_W-1:0]   num,
  input  logic [uvs_pkg::DEN_W-1:0]   den,
  output logic [uvs_pkg::NUM_W-1:0]   quo
);

  localparam int NW = uvs_pkg::NUM_W;
  localparam int DW = uvs_pkg::DEN_W;

  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] nq_r  [NW];   // dividend bits shift out the top, quotient bits in
  logic [DW-1:0] den_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [NW-1:0] nq_in;
    logic [DW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign nq_in  = nq_r[k-1];
      assign den_in = den_r[k-1];
    end

    // trial subtract; remainder always stays below the divisor
    assign trial = {rem_in, nq_in[NW-1]};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        nq_r[k]  <= {nq_in[NW-2:0], take};
        den_r[k] <= den_in;
      end
    end
  end

  assign quo = nq_r[NW-1];

endmodule

[sv/uv_sphere_vertex_generator_core.sv]
// Top level of the UV sphere vertex generator: pipeline, output serialiser, registers.
//
//  channel  direction  handshake            payload
//  in_      in         in_valid / in_stall  ring_index, segment_index
//  out_     out        out_valid/ out_stall attribute_kind, comp_x/y/z, last_attribute
//  cfg_     in         cfg_valid/ cfg_ready cfg_index, cfg_data
//
// A request passes one rounding stage, 35 divider stages (one quotient bit each) and eight
// trig/multiply stages, then the result register. Each request yields five results, one
// per cycle while out_stall is low; the single result register takes a new request only
// once its last result is taken. Reset clears valid bits and presets the config registers.
// A stall freezes the whole pipeline once its last stage holds a waiting request.
module uv_sphere_vertex_generator_core #(
  parameter int MAX_SEGMENTS = uvs_pkg::MAX_SEGMENTS_DEF,
  parameter int MAX_RINGS    = uvs_pkg::MAX_RINGS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [9:0]         in_ring_index,
  input  logic [10:0]        in_segment_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_attribute_kind,
  output logic signed [23:0] out_comp_x,
  output logic signed [23:0] out_comp_y,
  output logic signed [23:0] out_comp_z,
  output logic               out_last_attribute,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int NW = uvs_pkg::NUM_W;
  localparam int DW = uvs_pkg::DEN_W;
  localparam int PW = uvs_pkg::POLY_W;
  localparam int TW = uvs_pkg::TRIG_W;
  localparam int XW = uvs_pkg::TEX_W;
  localparam int OW = uvs_pkg::OUT_W;
  localparam int PB = uvs_pkg::PHASE_BITS;
  localparam int QB = uvs_pkg::QUARTER_BITS;
  localparam logic [XW-1:0] TEX_MAX = '1;

  // ---------------- configuration registers ----------------
  logic [15:0]   radius_r;
  logic [DW-1:0] slices_r;
  logic [DW-1:0] loops_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 16'd256;
      slices_r <= DW'(16);
      loops_r  <= DW'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        uvs_pkg::REG_RADIUS: radius_r <= cfg_data;
        uvs_pkg::REG_SLICES: slices_r <= cfg_data[DW-1:0];
        uvs_pkg::REG_LOOPS:  loops_r  <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline enable ----------------
  logic pipe_en;
  logic buf_take;
  logic h_v_r;

  assign pipe_en  = !h_v_r || buf_take;
  assign in_stall = !pipe_en;

  // ---------------- stage 0: clamp divisors, add rounding ----------------
  logic [DW-1:0] seg_div;
  logic [DW-1:0] ring_l;
  logic [DW-1:0] ring_div;

  always_comb begin
    if (slices_r == '0) seg_div = DW'(1);
    else if (32'(slices_r) > MAX_SEGMENTS) seg_div = DW'(MAX_SEGMENTS);
    else seg_div = slices_r;
    if (slices_r == '0) seg_div = DW'(1);
    if (32'(loops_r) < 2) ring_l = DW'(2);
    else if (32'(loops_r) > MAX_RINGS) ring_l = DW'(MAX_RINGS);
    else ring_l = loops_r;
    ring_div = ring_l - DW'(1);
  end

  logic          v0_r;
  logic [NW-1:0] num_lon_r, num_lat_r, num_u_r, num_v_r;
  logic [DW-1:0] seg_div_r, ring_div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (pipe_en) v0_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      num_lon_r  <= (NW'(in_segment_index) << PB) + NW'(seg_div >> 1);
      num_lat_r  <= (NW'(in_ring_index) << (PB - 1)) + NW'(ring_div >> 1);
      num_u_r    <= (NW'(in_segment_index) << uvs_pkg::TRIG_FRAC_BITS) + NW'(seg_div >> 1);
      num_v_r    <= (NW'(in_ring_index) << uvs_pkg::TRIG_FRAC_BITS) + NW'(ring_div >> 1);
      seg_div_r  <= seg_div;
      ring_div_r <= ring_div;
    end
  end

  // ---------------- divider lanes ----------------
  logic [NW-1:0] q_lon, q_lat, q_u, q_v;
  logic [NW-1:0] vdiv_r;

  uvs_div u_div_lon (.clk, .en(pipe_en), .num(num_lon_r), .den(seg_div_r),  .quo(q_lon));
  uvs_div u_div_lat (.clk, .en(pipe_en), .num(num_lat_r), .den(ring_div_r), .quo(q_lat));
  uvs_div u_div_u   (.clk, .en(pipe_en), .num(num_u_r),   .den(seg_div_r),  .quo(q_u));
  uvs_div u_div_v   (.clk, .en(pipe_en), .num(num_v_r),   .den(ring_div_r), .quo(q_v));

  always_ff @(posedge clk) begin
    if (!rst_n) vdiv_r <= '0;
    else if (pipe_en) vdiv_r <= {vdiv_r[NW-2:0], v0_r};
  end

  // ---------------- stage A: quadrant fold (lanes sj, cj, si, ci), texcoord saturation ----------------
  logic [PB-1:0] ph [4];
  logic [PW-1:0] a_x_nxt [4];
  logic [PW-1:0] a_x_r [4];
  logic [3:0]    a_neg_nxt, a_neg_r;
  logic [XW-1:0] a_u_nxt, a_v_nxt;
  logic [XW-1:0] a_u_r, a_v_r, b_u_r, b_v_r, c_u_r, c_v_r, d_u_r, d_v_r;
  logic [XW-1:0] e_u_r, e_v_r, f_u_r, f_v_r, g_u_r, g_v_r;
  logic          a_v;
  logic          a_vr, b_vr, c_vr, d_vr, e_vr, f_vr, g_vr;

  always_comb begin
    logic [QB:0] fq;
    ph[0] = q_lat[PB-1:0];
    ph[1] = q_lat[PB-1:0] + (PB'(1) << QB);
    ph[2] = q_lon[PB-1:0];
    ph[3] = q_lon[PB-1:0] + (PB'(1) << QB);
    for (int k = 0; k < 4; k++) begin
      fq = {1'b0, ph[k][QB-1:0]};
      if (ph[k][QB]) fq = ((QB+1)'(1) << QB) - fq;
      a_x_nxt[k]   = PW'(fq) << (30 - QB);
      a_neg_nxt[k] = ph[k][PB-1];
    end
    a_u_nxt = (q_u > NW'(TEX_MAX)) ? TEX_MAX : q_u[XW-1:0];
    a_v_nxt = (q_v > NW'(TEX_MAX)) ? TEX_MAX : q_v[XW-1:0];
  end

  // ---------------- stages B..E: sine polynomial ----------------
  logic [PW-1:0] b_x_r [4], b_x2_r [4];
  logic [PW-1:0] c_x_r [4], c_x2_r [4], c_t_r [4];
  logic [PW-1:0] d_x_r [4], d_t_r [4];
  logic [PW-1:0] e_t_r [4];
  logic [3:0]    b_neg_r, c_neg_r, d_neg_r, e_neg_r;

  logic [PW-1:0] b_x2_nxt [4], c_t_nxt [4], d_t_nxt [4], e_t_nxt [4];
  logic signed [TW-1:0] f_s_nxt [4];

  always_comb begin
    logic [2*PW-1:0] p;
    logic [31:0]     r;
    for (int k = 0; k < 4; k++) begin
      p = (2*PW)'(a_x_r[k]) * (2*PW)'(a_x_r[k]);
      b_x2_nxt[k] = p[PW+29:30];
      p = (2*PW)'(uvs_pkg::POLY_C) * (2*PW)'(b_x2_r[k]);
      c_t_nxt[k] = uvs_pkg::POLY_B - p[PW+29:30];
      p = (2*PW)'(c_t_r[k]) * (2*PW)'(c_x2_r[k]);
      d_t_nxt[k] = uvs_pkg::POLY_A - p[PW+29:30];
      p = (2*PW)'(d_t_r[k]) * (2*PW)'(d_x_r[k]);
      e_t_nxt[k] = p[PW+29:30];
      // round half up to Q1.14, then apply quadrant sign
      r = (32'(e_t_r[k]) + (32'(1) << (uvs_pkg::SIN_SHIFT - 1))) >> uvs_pkg::SIN_SHIFT;
      f_s_nxt[k] = e_neg_r[k] ? -$signed(r[TW-1:0]) : $signed(r[TW-1:0]);
    end
  end

  // ---------------- stage F/G/H: products and position ----------------
  logic signed [TW-1:0] f_s_r [4];     // 0 sj, 1 cj, 2 si, 3 ci
  logic signed [TW-1:0] g_sj_r, g_cj_r, g_si_r, g_ci_r;
  logic signed [TW-1:0] g_nx_r, g_nzp_r, g_bx_r, g_bzp_r;
  logic signed [47:0]   g_nx_w, g_nzp_w, g_bx_w, g_bzp_w;

  assign g_nx_w  = uvs_pkg::round_q(48'(f_s_r[0]) * 48'(f_s_r[3]));
  assign g_nzp_w = uvs_pkg::round_q(48'(f_s_r[0]) * 48'(f_s_r[2]));
  assign g_bx_w  = uvs_pkg::round_q(48'(f_s_r[1]) * 48'(f_s_r[3]));
  assign g_bzp_w = uvs_pkg::round_q(48'(f_s_r[1]) * 48'(f_s_r[2]));

  logic signed [OW-1:0] nx_e, ny_e, nz_e;
  logic signed [16:0]   rad_s;
  logic signed [47:0]   px_w, py_w, pz_w;

  assign nx_e  = OW'(g_nx_r);
  assign ny_e  = -OW'(g_cj_r);
  assign nz_e  = -OW'(g_nzp_r);
  assign rad_s = $signed({1'b0, radius_r});
  assign px_w  = uvs_pkg::round_q(48'(nx_e) * 48'(rad_s));
  assign py_w  = uvs_pkg::round_q(48'(ny_e) * 48'(rad_s));
  assign pz_w  = uvs_pkg::round_q(48'(nz_e) * 48'(rad_s));

  logic signed [OW-1:0] h_pos_r [3], h_nrm_r [3], h_tan_r [2], h_bin_r [3];
  logic [XW-1:0]        h_u_r, h_tv_r;

  // valid bits
  assign a_v = vdiv_r[NW-1];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vr <= 1'b0; b_vr <= 1'b0; c_vr <= 1'b0; d_vr <= 1'b0;
      e_vr <= 1'b0; f_vr <= 1'b0; g_vr <= 1'b0; h_v_r <= 1'b0;
    end else if (pipe_en) begin
      a_vr <= a_v;  b_vr <= a_vr; c_vr <= b_vr; d_vr <= c_vr;
      e_vr <= d_vr; f_vr <= e_vr; g_vr <= f_vr; h_v_r <= g_vr;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < 4; k++) begin
        a_x_r[k]  <= a_x_nxt[k];
        b_x_r[k]  <= a_x_r[k];
        b_x2_r[k] <= b_x2_nxt[k];
        c_x_r[k]  <= b_x_r[k];
        c_x2_r[k] <= b_x2_r[k];
        c_t_r[k]  <= c_t_nxt[k];
        d_x_r[k]  <= c_x_r[k];
        d_t_r[k]  <= d_t_nxt[k];
        e_t_r[k]  <= e_t_nxt[k];
        f_s_r[k]  <= f_s_nxt[k];
      end
      a_neg_r <= a_neg_nxt; b_neg_r <= a_neg_r; c_neg_r <= b_neg_r;
      d_neg_r <= c_neg_r;   e_neg_r <= d_neg_r;
      a_u_r <= a_u_nxt; a_v_r <= a_v_nxt;
      b_u_r <= a_u_r;   b_v_r <= a_v_r;
      c_u_r <= b_u_r;   c_v_r <= b_v_r;
      d_u_r <= c_u_r;   d_v_r <= c_v_r;
      e_u_r <= d_u_r;   e_v_r <= d_v_r;
      f_u_r <= e_u_r;   f_v_r <= e_v_r;
      g_u_r <= f_u_r;   g_v_r <= f_v_r;
      // stage G
      g_sj_r  <= f_s_r[0];
      g_cj_r  <= f_s_r[1];
      g_si_r  <= f_s_r[2];
      g_ci_r  <= f_s_r[3];
      g_nx_r  <= TW'(g_nx_w);
      g_nzp_r <= TW'(g_nzp_w);
      g_bx_r  <= TW'(g_bx_w);
      g_bzp_r <= TW'(g_bzp_w);
      // stage H
      h_pos_r[0] <= OW'(px_w);
      h_pos_r[1] <= OW'(py_w);
      h_pos_r[2] <= OW'(pz_w);
      h_nrm_r[0] <= nx_e;
      h_nrm_r[1] <= ny_e;
      h_nrm_r[2] <= nz_e;
      h_tan_r[0] <= -OW'(g_si_r);
      h_tan_r[1] <= -OW'(g_ci_r);
      h_bin_r[0] <= OW'(g_bx_r);
      h_bin_r[1] <= OW'(g_sj_r);
      h_bin_r[2] <= -OW'(g_bzp_r);
      h_u_r  <= g_u_r;
      h_tv_r <= g_v_r;
    end
  end

  // ---------------- result register and serialiser ----------------
  logic                 full_r, full_nxt;
  logic [2:0]           kind_r, kind_nxt;
  logic signed [OW-1:0] o_pos_r [3], o_nrm_r [3], o_tan_r [2], o_bin_r [3];
  logic [XW-1:0]        o_u_r, o_v_r;
  logic                 out_fire;

  assign out_fire = out_valid && !out_stall;
  assign buf_take = !full_r || (out_fire && kind_r == uvs_pkg::KIND_BIN);

  always_comb begin
    full_nxt = full_r;
    kind_nxt = kind_r;
    if (buf_take) begin
      full_nxt = h_v_r;
      kind_nxt = uvs_pkg::KIND_POS;
    end else if (out_fire) begin
      kind_nxt = kind_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      kind_r <= uvs_pkg::KIND_POS;
    end else begin
      full_r <= full_nxt;
      kind_r <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_take) begin
      o_pos_r <= h_pos_r;
      o_nrm_r <= h_nrm_r;
      o_tan_r <= h_tan_r;
      o_bin_r <= h_bin_r;
      o_u_r   <= h_u_r;
      o_v_r   <= h_tv_r;
    end
  end

  assign out_valid          = full_r;
  assign out_attribute_kind = kind_r;
  assign out_last_attribute = (kind_r == uvs_pkg::KIND_BIN);

  always_comb begin
    case (kind_r)
      uvs_pkg::KIND_POS: begin
        out_comp_x = o_pos_r[0]; out_comp_y = o_pos_r[1]; out_comp_z = o_pos_r[2];
      end
      uvs_pkg::KIND_NRM: begin
        out_comp_x = o_nrm_r[0]; out_comp_y = o_nrm_r[1]; out_comp_z = o_nrm_r[2];
      end
      uvs_pkg::KIND_TEX: begin
        out_comp_x = OW'(o_u_r); out_comp_y = OW'(o_v_r); out_comp_z = '0;
      end
      uvs_pkg::KIND_TAN: begin
        out_comp_x = o_tan_r[0]; out_comp_y = '0; out_comp_z = o_tan_r[1];
      end
      default: begin
        out_comp_x = o_bin_r[0]; out_comp_y = o_bin_r[1]; out_comp_z = o_bin_r[2];
      end
    endcase
  end

`ifndef SYNTHESIS
  // the kind steps by one on every taken result short of the last
  a_kind_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && kind_r != uvs_pkg::KIND_BIN |=> out_valid && kind_r == $past(kind_r) + 3'd1)
    else $error("attribute kind did not advance");

  // input is only held off while the last stage holds a request
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> h_v_r && full_r)
    else $error("input stalled without a waiting request");

  // an empty result register always restarts at position
  a_empty_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !full_r |-> kind_r == uvs_pkg::KIND_POS)
    else $error("kind not reset while result register empty");

  // a finished binormal frees the result register unless a request follows
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && kind_r == uvs_pkg::KIND_BIN && !h_v_r |=> !full_r)
    else $error("result register stayed full after last attribute");
`endif

endmodule
